[rtl/core/pmeter_pkg.sv]
package pmeter_pkg;

	// Block constants
	localparam int TICKS_PER_REPORT = 100;
	localparam int SAMPLE_BITS      = 10;

	// Field and register widths
	localparam int ACT_W     = 2;
	localparam int MODE_W    = 2;
	localparam int TICK_W    = 10;
	localparam int SUM_W     = 20;
	localparam int GAIN_W    = 20;
	localparam int OFS_W     = 24;
	localparam int REF_W     = 27;
	localparam int PERIOD_W  = 32;
	localparam int CFG_W     = 27;
	localparam int CFG_IDX_W = 3;
	localparam int DIGIT_W   = 4;
	localparam int CODE_W    = 2;

	// Datapath widths
	localparam int MEAN_W    = $clog2((2**SUM_W - 1) / TICKS_PER_REPORT + 1);
	localparam int PROD_W    = MEAN_W + GAIN_W;
	localparam int VAL_W     = PROD_W + 2;
	localparam int UVAL_W    = VAL_W - 1;
	localparam int FRAC_W    = 16;
	localparam int DISP_W    = 10;
	localparam int DIV_W     = REF_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
	localparam logic [DISP_W-1:0] DISP_MAX = DISP_W'(999);

	// Register reset values
	localparam logic [GAIN_W-1:0] DCV_GAIN_RST = GAIN_W'(9103);
	localparam logic [OFS_W-1:0]  DCV_OFS_RST  = OFS_W'(-80065);
	localparam logic [GAIN_W-1:0] DCI_GAIN_RST = GAIN_W'(3414);
	localparam logic [OFS_W-1:0]  DCI_OFS_RST  = OFS_W'(-55673);
	localparam logic [GAIN_W-1:0] AC_GAIN_RST  = GAIN_W'(6501);
	localparam logic [OFS_W-1:0]  AC_OFS_RST   = OFS_W'(335341);
	localparam logic [REF_W-1:0]  REF_HZ_RST   = REF_W'(48000000);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DCV_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DCV_OFS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DCI_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DCI_OFS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AC_GAIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AC_OFS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REF_HZ   = 3'd6;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BUTTON = 2'd2;

	// Meter modes
	localparam logic [MODE_W-1:0] MODE_DCV  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DCI  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AC   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FREQ = 2'd3;

	// Decimal point and unit codes
	localparam logic [CODE_W-1:0] PT_NONE     = 2'd0;
	localparam logic [CODE_W-1:0] PT_TENS     = 2'd1;
	localparam logic [CODE_W-1:0] PT_HUNDREDS = 2'd2;
	localparam logic [CODE_W-1:0] UNIT_VALUE  = 2'd0;
	localparam logic [CODE_W-1:0] UNIT_HZ     = 2'd1;
	localparam logic [CODE_W-1:0] UNIT_KHZ    = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic div_start;
		logic mul_en;
		logic add_en;
		logic fmt_en;
		logic out_load;
	} pm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic report;
		logic div_busy;
		logic out_free;
	} pm_sts_t;

endpackage

[rtl/core/pmeter_div.sv]
module pmeter_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pmeter_pkg::DIV_W-1:0]      dividend,
	input  logic [pmeter_pkg::PERIOD_W-1:0]   divisor,
	output logic                              busy,
	output logic [pmeter_pkg::DIV_W-1:0]      quotient
);

	logic                                busy_q;
	logic [pmeter_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [pmeter_pkg::DIV_W-1:0]        quo_q;
	logic [pmeter_pkg::DIV_W-1:0]        rem_q;
	logic [pmeter_pkg::PERIOD_W-1:0]     dvs_q;
	logic [pmeter_pkg::DIV_W:0]          rem_sh;
	logic [pmeter_pkg::DIV_W:0]          rem_sub;
	logic                                fits;

	// One restoring step: bring in the next dividend bit, subtract if it fits
	assign rem_sh  = {rem_q, quo_q[pmeter_pkg::DIV_W-1]};
	assign fits    = pmeter_pkg::PERIOD_W'(rem_sh) >= dvs_q;
	assign rem_sub = rem_sh - dvs_q[pmeter_pkg::DIV_W:0];

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= pmeter_pkg::DIV_CNT_W'(pmeter_pkg::DIV_W);
		end else if (busy_q) begin
			busy_q <= (cnt_q != pmeter_pkg::DIV_CNT_W'(1));
			cnt_q  <= cnt_q - pmeter_pkg::DIV_CNT_W'(1);
		end
	end

	// Remainder and shifting quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[pmeter_pkg::DIV_W-1:0] : rem_sh[pmeter_pkg::DIV_W-1:0];
			quo_q <= {quo_q[pmeter_pkg::DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

[rtl/core/pmeter_ctrl.sv]
module pmeter_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pmeter_pkg::pm_sts_t  sts,
	output pmeter_pkg::pm_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_ADD  = 6'b001000,
		ST_FMT  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// Commands
	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.div_start = accept && sts.report;
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.add_en    = (state_q == ST_ADD);
		cmd.fmt_en    = (state_q == ST_FMT);
		cmd.out_load  = (state_q == ST_OUT) && sts.out_free;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.report) state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (!sts.div_busy) state_nx = ST_MUL;
			end
			ST_MUL:  state_nx = ST_ADD;
			ST_ADD:  state_nx = ST_FMT;
			ST_FMT:  state_nx = ST_OUT;
			ST_OUT: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

`ifndef SYNTHESIS
	// Divider only runs while a report is in flight
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.div_busy)
		else $error("divider busy while controller idle");

	// A reporting tick starts the division
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_DIV) && sts.div_busy)
		else $error("report accepted but division not running");

	// Result is never loaded over an untaken one
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten");
`endif

endmodule

[rtl/core/pmeter_dp.sv]
module pmeter_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [pmeter_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pmeter_pkg::CFG_W-1:0]         cfg_data,
	input  logic [pmeter_pkg::ACT_W-1:0]         action,
	input  logic [pmeter_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic [pmeter_pkg::PERIOD_W-1:0]      period_count,
	input  pmeter_pkg::pm_cmd_t                  cmd,
	output pmeter_pkg::pm_sts_t                  sts,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic [pmeter_pkg::DIGIT_W-1:0]       digit_ones,
	output logic [pmeter_pkg::DIGIT_W-1:0]       digit_tens,
	output logic [pmeter_pkg::DIGIT_W-1:0]       digit_hundreds,
	output logic [pmeter_pkg::CODE_W-1:0]        point_after,
	output logic [pmeter_pkg::CODE_W-1:0]        unit_code
);

	localparam int SMALL_W = pmeter_pkg::FRAC_W + 4;   // holds 10.0 in Q16
	localparam int MID_W   = pmeter_pkg::FRAC_W + 7;   // holds 100.0 in Q16
	localparam int MUL_W   = 27;
	localparam int REM_W   = 7;

	// Configuration registers
	logic [pmeter_pkg::GAIN_W-1:0] dcv_gain_q, dci_gain_q, ac_gain_q;
	logic [pmeter_pkg::OFS_W-1:0]  dcv_ofs_q, dci_ofs_q, ac_ofs_q;
	logic [pmeter_pkg::REF_W-1:0]  ref_hz_q;

	// Meter state
	logic [pmeter_pkg::MODE_W-1:0]      mode_q;
	logic [pmeter_pkg::TICK_W-1:0]      tick_q;
	logic [pmeter_pkg::SAMPLE_BITS-1:0] last_q, peak_q;
	logic [pmeter_pkg::SUM_W-1:0]       ssum_q, psum_q;
	logic [pmeter_pkg::SUM_W-1:0]       ssum_nx, psum_nx;
	logic [pmeter_pkg::SUM_W:0]         ssum_add, psum_add;
	logic                               report;

	// Division
	logic [pmeter_pkg::DIV_W-1:0]    div_dvd;
	logic [pmeter_pkg::PERIOD_W-1:0] div_dvs;
	logic [pmeter_pkg::DIV_W-1:0]    quotient;
	logic                            div_busy;
	logic                            per_zero_q;

	// Scale and format
	logic [pmeter_pkg::GAIN_W-1:0]        gain_sel;
	logic [pmeter_pkg::OFS_W-1:0]         ofs_sel;
	logic [pmeter_pkg::PROD_W-1:0]        prod_q;
	logic signed [pmeter_pkg::VAL_W-1:0]  val_q;
	logic [pmeter_pkg::UVAL_W-1:0]        uval;
	logic [pmeter_pkg::UVAL_W-pmeter_pkg::FRAC_W-1:0] int_part;
	logic [MUL_W-1:0]                     p100, p10, pf10;
	logic [pmeter_pkg::DISP_W-1:0]        disp_nx, disp_q;
	logic [pmeter_pkg::CODE_W-1:0]        pt_nx, pt_q, unit_nx, unit_q;

	// Digit split
	logic [15:0]                          hund_p;
	logic [pmeter_pkg::DIGIT_W-1:0]       hund;
	logic [pmeter_pkg::DISP_W-1:0]        rem_h;
	logic [REM_W-1:0]                     rem7;
	logic [14:0]                          tens_p;
	logic [pmeter_pkg::DIGIT_W-1:0]       tens;
	logic [REM_W-1:0]                     ones7;

	logic                                 out_valid_q;
	logic [pmeter_pkg::DIGIT_W-1:0]       ones_q, tens_q, hund_q;
	logic [pmeter_pkg::CODE_W-1:0]        point_q, unitc_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcv_gain_q <= pmeter_pkg::DCV_GAIN_RST;
			dcv_ofs_q  <= pmeter_pkg::DCV_OFS_RST;
			dci_gain_q <= pmeter_pkg::DCI_GAIN_RST;
			dci_ofs_q  <= pmeter_pkg::DCI_OFS_RST;
			ac_gain_q  <= pmeter_pkg::AC_GAIN_RST;
			ac_ofs_q   <= pmeter_pkg::AC_OFS_RST;
			ref_hz_q   <= pmeter_pkg::REF_HZ_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pmeter_pkg::REG_DCV_GAIN: dcv_gain_q <= cfg_data[pmeter_pkg::GAIN_W-1:0];
				pmeter_pkg::REG_DCV_OFS:  dcv_ofs_q  <= cfg_data[pmeter_pkg::OFS_W-1:0];
				pmeter_pkg::REG_DCI_GAIN: dci_gain_q <= cfg_data[pmeter_pkg::GAIN_W-1:0];
				pmeter_pkg::REG_DCI_OFS:  dci_ofs_q  <= cfg_data[pmeter_pkg::OFS_W-1:0];
				pmeter_pkg::REG_AC_GAIN:  ac_gain_q  <= cfg_data[pmeter_pkg::GAIN_W-1:0];
				pmeter_pkg::REG_AC_OFS:   ac_ofs_q   <= cfg_data[pmeter_pkg::OFS_W-1:0];
				pmeter_pkg::REG_REF_HZ:   ref_hz_q   <= cfg_data[pmeter_pkg::REF_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturating sums including this tick
	assign ssum_add = {1'b0, ssum_q} + (pmeter_pkg::SUM_W+1)'(last_q);
	assign psum_add = {1'b0, psum_q} + (pmeter_pkg::SUM_W+1)'(peak_q);
	assign ssum_nx  = ssum_add[pmeter_pkg::SUM_W] ? pmeter_pkg::SUM_MAX
		: ssum_add[pmeter_pkg::SUM_W-1:0];
	assign psum_nx  = psum_add[pmeter_pkg::SUM_W] ? pmeter_pkg::SUM_MAX
		: psum_add[pmeter_pkg::SUM_W-1:0];

	assign report = (action == pmeter_pkg::ACT_TICK)
		&& (tick_q == pmeter_pkg::TICK_W'(pmeter_pkg::TICKS_PER_REPORT - 1));

	// Per-transaction state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pmeter_pkg::MODE_DCV;
			tick_q <= '0;
			last_q <= '0;
			peak_q <= '0;
			ssum_q <= '0;
			psum_q <= '0;
		end else if (cmd.accept) begin
			case (action)
				pmeter_pkg::ACT_SAMPLE: begin
					last_q <= sample;
					if (sample > peak_q) peak_q <= sample;
				end
				pmeter_pkg::ACT_TICK: begin
					peak_q <= '0;
					if (report) begin
						tick_q <= '0;
						ssum_q <= '0;
						psum_q <= '0;
					end else begin
						tick_q <= tick_q + pmeter_pkg::TICK_W'(1);
						ssum_q <= ssum_nx;
						psum_q <= psum_nx;
					end
				end
				pmeter_pkg::ACT_BUTTON: mode_q <= mode_q + pmeter_pkg::MODE_W'(1);
				default: ;
			endcase
		end
	end

	// Divider operands: frequency or mean of the selected sum
	always_comb begin
		if (mode_q == pmeter_pkg::MODE_FREQ) begin
			div_dvd = ref_hz_q;
			div_dvs = period_count;
		end else begin
			div_dvd = (mode_q == pmeter_pkg::MODE_AC) ? pmeter_pkg::DIV_W'(psum_nx)
				: pmeter_pkg::DIV_W'(ssum_nx);
			div_dvs = pmeter_pkg::PERIOD_W'(pmeter_pkg::TICKS_PER_REPORT);
		end
	end

	pmeter_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) per_zero_q <= (period_count == '0);
	end

	// Gain and offset by mode
	always_comb begin
		case (mode_q)
			pmeter_pkg::MODE_DCV: begin
				gain_sel = dcv_gain_q;
				ofs_sel  = dcv_ofs_q;
			end
			pmeter_pkg::MODE_DCI: begin
				gain_sel = dci_gain_q;
				ofs_sel  = dci_ofs_q;
			end
			default: begin
				gain_sel = ac_gain_q;
				ofs_sel  = ac_ofs_q;
			end
		endcase
	end

	// Multiply, then add offset
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= pmeter_pkg::PROD_W'(quotient[pmeter_pkg::MEAN_W-1:0])
				* pmeter_pkg::PROD_W'(gain_sel);
		end
		if (cmd.add_en) begin
			val_q <= $signed({2'b00, prod_q})
				+ pmeter_pkg::VAL_W'($signed(ofs_sel));
		end
	end

	// Clamp at zero; AC mode keeps the integer part only
	always_comb begin
		uval = val_q[pmeter_pkg::VAL_W-1] ? '0 : val_q[pmeter_pkg::UVAL_W-1:0];
		if (mode_q == pmeter_pkg::MODE_AC) uval[pmeter_pkg::FRAC_W-1:0] = '0;
	end

	assign int_part = uval[pmeter_pkg::UVAL_W-1:pmeter_pkg::FRAC_W];
	assign p100 = MUL_W'(uval[SMALL_W-1:0]) * MUL_W'(100);
	assign p10  = MUL_W'(uval[MID_W-1:0]) * MUL_W'(10);
	assign pf10 = MUL_W'(quotient[13:0]) * MUL_W'(6554);

	// Pick display number, point and unit
	always_comb begin
		disp_nx = pmeter_pkg::DISP_MAX;
		pt_nx   = pmeter_pkg::PT_HUNDREDS;
		unit_nx = pmeter_pkg::UNIT_KHZ;
		if (mode_q == pmeter_pkg::MODE_FREQ) begin
			if (per_zero_q) begin
				disp_nx = pmeter_pkg::DISP_MAX;
			end else if (quotient < pmeter_pkg::DIV_W'(1000)) begin
				disp_nx = quotient[pmeter_pkg::DISP_W-1:0];
				pt_nx   = pmeter_pkg::PT_NONE;
				unit_nx = pmeter_pkg::UNIT_HZ;
			end else if (quotient < pmeter_pkg::DIV_W'(10000)) begin
				// divide by ten via reciprocal, exact below 16384
				disp_nx = pf10[pmeter_pkg::FRAC_W+pmeter_pkg::DISP_W-1:pmeter_pkg::FRAC_W];
			end
		end else begin
			unit_nx = pmeter_pkg::UNIT_VALUE;
			if (uval < pmeter_pkg::UVAL_W'(10 << pmeter_pkg::FRAC_W)) begin
				disp_nx = p100[pmeter_pkg::FRAC_W+pmeter_pkg::DISP_W-1:pmeter_pkg::FRAC_W];
				pt_nx   = pmeter_pkg::PT_HUNDREDS;
			end else if (uval < pmeter_pkg::UVAL_W'(100 << pmeter_pkg::FRAC_W)) begin
				disp_nx = p10[pmeter_pkg::FRAC_W+pmeter_pkg::DISP_W-1:pmeter_pkg::FRAC_W];
				pt_nx   = pmeter_pkg::PT_TENS;
			end else begin
				pt_nx   = pmeter_pkg::PT_NONE;
				disp_nx = (int_part > $bits(int_part)'(999)) ? pmeter_pkg::DISP_MAX
					: int_part[pmeter_pkg::DISP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fmt_en) begin
			disp_q <= disp_nx;
			pt_q   <= pt_nx;
			unit_q <= unit_nx;
		end
	end

	// Decimal digits by reciprocal multiplies (exact for 0..999)
	assign hund_p = 16'(disp_q) * 16'(41);
	assign hund   = hund_p[15:12];
	assign rem_h  = disp_q - pmeter_pkg::DISP_W'(hund) * pmeter_pkg::DISP_W'(100);
	assign rem7   = rem_h[REM_W-1:0];
	assign tens_p = 15'(rem7) * 15'(205);
	assign tens   = tens_p[14:11];
	assign ones7  = rem7 - REM_W'(tens) * REM_W'(10);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ones_q  <= ones7[pmeter_pkg::DIGIT_W-1:0];
			tens_q  <= tens;
			hund_q  <= hund;
			point_q <= pt_q;
			unitc_q <= unit_q;
		end
	end

	assign sts.report   = report;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign digit_ones     = ones_q;
	assign digit_tens     = tens_q;
	assign digit_hundreds = hund_q;
	assign point_after    = point_q;
	assign unit_code      = unitc_q;

`ifndef SYNTHESIS
	// Digit split stays decimal
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_ones <= 4'd9 && digit_tens <= 4'd9 && digit_hundreds <= 4'd9))
		else $error("digit out of decimal range");

	// Point and unit codes are meaningful
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_after <= pmeter_pkg::PT_HUNDREDS
			&& unit_code <= pmeter_pkg::UNIT_KHZ))
		else $error("bad point or unit code");

	// Tick counter restarts at the report boundary
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < pmeter_pkg::TICK_W'(pmeter_pkg::TICKS_PER_REPORT))
		else $error("tick counter past report count");
`endif

endmodule

[rtl/core/panel_meter_average_scale_format_top.sv]
// Sample, button and non-reporting tick transactions: accepted one per cycle while
// in_stall is low, no result. Reporting tick: input stalled until the result is loaded
// through the restoring divider (one quotient bit per cycle, shared by mean and
// frequency), multiply, add and format. The result register holds until taken;
// a later report waits for it. Reset (arst_n low, asynchronous): mode, counter,
// sums, samples and handshake cleared, configuration registers to their default values.
module panel_meter_average_scale_format_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [pmeter_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pmeter_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pmeter_pkg::ACT_W-1:0]         action,
	input  logic [pmeter_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic [pmeter_pkg::PERIOD_W-1:0]      period_count,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pmeter_pkg::DIGIT_W-1:0]       digit_ones,
	output logic [pmeter_pkg::DIGIT_W-1:0]       digit_tens,
	output logic [pmeter_pkg::DIGIT_W-1:0]       digit_hundreds,
	output logic [pmeter_pkg::CODE_W-1:0]        point_after,
	output logic [pmeter_pkg::CODE_W-1:0]        unit_code
);

	pmeter_pkg::pm_cmd_t cmd;
	pmeter_pkg::pm_sts_t sts;

	pmeter_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pmeter_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.sample         (sample),
		.period_count   (period_count),
		.cmd            (cmd),
		.sts            (sts),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.digit_ones     (digit_ones),
		.digit_tens     (digit_tens),
		.digit_hundreds (digit_hundreds),
		.point_after    (point_after),
		.unit_code      (unit_code)
	);

endmodule
